// ===== sv/pbfl_pkg.sv =====
// ----------------------------------------------------------------------------
// pbfl_pkg
// Shared types and constants of the packet buffer free list allocator.
// ----------------------------------------------------------------------------
package pbfl_pkg;

	localparam int ADDR_W      = 15;
	localparam int OP_W        = 2;
	localparam int STATUS_W    = 2;
	localparam int REG_W       = 5;
	localparam int CNT_W       = 5;
	localparam int CFG_INDEX_W = 1;

	localparam int BLOCK_COUNT_DEF = 16;
	localparam int BLOCK_BYTES_DEF = 2048;

	localparam logic [REG_W-1:0] RX_LIMIT_RST = 5'd8;
	localparam logic [REG_W-1:0] TX_LIMIT_RST = 5'd8;

	localparam logic [CFG_INDEX_W-1:0] REG_RX_LIMIT = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TX_LIMIT = 1'd1;

	localparam logic [OP_W-1:0] OP_ALLOC_RX = 2'd0;
	localparam logic [OP_W-1:0] OP_ALLOC_TX = 2'd1;
	localparam logic [OP_W-1:0] OP_FREE_RX  = 2'd2;
	localparam logic [OP_W-1:0] OP_FREE_TX  = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_LIMIT     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [ADDR_W-1:0] address;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0]   block_address;
	} rsp_t;

endpackage

// ===== sv/packet_buffer_free_list_unit.sv =====
// ----------------------------------------------------------------------------
// packet_buffer_free_list_unit
// Pool allocator: LIFO free list of equal packet blocks with per-class
// allocation counts capped by limit registers.
// ----------------------------------------------------------------------------
// Each request word first reads the link of the current head block from the
// link memory into a register, then decides, updates the head, the counts
// and the link memory, and loads the response register. A new word is taken
// only once the previous one has completed; the response register lets the
// next word in while a response still waits. After reset the link memory is
// initialized by a pass over every block, during which req_stall stays high;
// configuration writes are taken at all times. Frees round the address down
// to its block; a free beyond the pool is ignored with status ok.
module packet_buffer_free_list_unit #(
	parameter int BLOCK_COUNT = pbfl_pkg::BLOCK_COUNT_DEF,
	parameter int BLOCK_BYTES = pbfl_pkg::BLOCK_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pbfl_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [pbfl_pkg::REG_W-1:0]       cfg_data,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  pbfl_pkg::req_t                   req,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output pbfl_pkg::rsp_t                   rsp
);
	import pbfl_pkg::*;

	localparam int IW    = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
	localparam int LW    = $clog2(BLOCK_COUNT + 1);
	localparam int SHIFT = ADDR_W + $clog2(BLOCK_BYTES);
	localparam longint RECIP_L = ((64'd1 << SHIFT) + BLOCK_BYTES - 1) / BLOCK_BYTES;
	localparam int RW    = 17;
	localparam int PW    = ADDR_W + RW;
	localparam logic [RW-1:0]  RECIP   = RW'(RECIP_L);
	localparam logic [LW-1:0]  NULL_LK = LW'(BLOCK_COUNT);
	localparam logic [IW-1:0]  LAST_IX = IW'(BLOCK_COUNT - 1);

	localparam logic [1:0] S_INIT = 2'd0;
	localparam logic [1:0] S_IDLE = 2'd1;
	localparam logic [1:0] S_EXEC = 2'd2;

	logic [LW-1:0] link_mem [BLOCK_COUNT];

	logic [1:0]       state_q;
	logic [IW-1:0]    init_idx_q;
	logic [LW-1:0]    free_head_q;
	logic [CNT_W-1:0] rx_count_q, tx_count_q;
	logic [REG_W-1:0] rx_limit_q, tx_limit_q;
	logic [OP_W-1:0]  op_s1;
	logic [PW-1:0]    prod_s1;
	logic [LW-1:0]    rd_link_s1;
	logic             out_valid_q;
	rsp_t             out_q;

	logic             accept, out_free, exec_go;
	logic             mem_we;
	logic [IW-1:0]    mem_waddr;
	logic [LW-1:0]    mem_wdata;
	logic             is_tx;
	logic [CNT_W-1:0] cnt_sel;
	logic [REG_W-1:0] lim_sel;
	logic [PW-1:0]    quo_full;
	logic [15:0]      blk_idx;
	logic             blk_in_pool;
	logic [31:0]      base_addr;
	rsp_t             rsp_d;
	logic [LW-1:0]    head_d;
	logic [CNT_W-1:0] cnt_d;
	logic             cnt_upd;
	logic             free_push;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign out_free  = !out_valid_q || !rsp_stall;
	assign exec_go   = (state_q == S_EXEC) && out_free;

	assign is_tx       = (op_s1 == OP_ALLOC_TX) || (op_s1 == OP_FREE_TX);
	assign cnt_sel     = is_tx ? tx_count_q : rx_count_q;
	assign lim_sel     = is_tx ? tx_limit_q : rx_limit_q;
	assign quo_full    = prod_s1 >> SHIFT;
	assign blk_idx     = quo_full[15:0];
	assign blk_in_pool = (32'(blk_idx) < 32'(BLOCK_COUNT));
	assign base_addr   = 32'(free_head_q) * 32'(BLOCK_BYTES);

	always_comb begin
		rsp_d     = '{status: ST_OK, block_address: '0};
		head_d    = free_head_q;
		cnt_d     = cnt_sel;
		cnt_upd   = 1'b0;
		free_push = 1'b0;
		case (op_s1)
			OP_ALLOC_RX, OP_ALLOC_TX: begin
				if (cnt_sel >= lim_sel) begin
					rsp_d.status = ST_LIMIT;
				end else if (free_head_q >= NULL_LK) begin
					rsp_d.status = ST_EMPTY;
				end else begin
					head_d  = rd_link_s1;
					cnt_d   = cnt_sel + CNT_W'(1);
					cnt_upd = 1'b1;
					if (op_s1 == OP_ALLOC_TX) begin
						rsp_d.block_address = ADDR_W'(base_addr + 32'(BLOCK_BYTES - 1));
					end else begin
						rsp_d.block_address = ADDR_W'(base_addr);
					end
				end
			end
			OP_FREE_RX, OP_FREE_TX: begin
				if (blk_in_pool) begin
					if (cnt_sel == '0) begin
						rsp_d.status = ST_UNDERFLOW;
					end else begin
						head_d    = LW'(blk_idx);
						cnt_d     = cnt_sel - CNT_W'(1);
						cnt_upd   = 1'b1;
						free_push = 1'b1;
					end
				end
			end
			default: begin
				rsp_d.status = ST_OK;
			end
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = init_idx_q;
		mem_wdata = LW'(init_idx_q) + LW'(1);
		if (state_q == S_INIT) begin
			mem_we = 1'b1;
		end else if (exec_go && free_push) begin
			mem_we    = 1'b1;
			mem_waddr = IW'(blk_idx);
			mem_wdata = free_head_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[mem_waddr] <= mem_wdata;
		end
		if (accept) begin
			rd_link_s1 <= link_mem[free_head_q[IW-1:0]];
			op_s1      <= req.op;
			prod_s1    <= PW'(req.address) * PW'(RECIP);
		end
		if (exec_go) begin
			out_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			init_idx_q  <= '0;
			free_head_q <= '0;
			rx_count_q  <= '0;
			tx_count_q  <= '0;
			rx_limit_q  <= RX_LIMIT_RST;
			tx_limit_q  <= TX_LIMIT_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_RX_LIMIT: rx_limit_q <= cfg_data;
					REG_TX_LIMIT: tx_limit_q <= cfg_data;
					default: begin
					end
				endcase
			end
			case (state_q)
				S_INIT: begin
					init_idx_q <= init_idx_q + IW'(1);
					if (init_idx_q == LAST_IX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (exec_go) begin
						state_q     <= S_IDLE;
						free_head_q <= head_d;
						if (cnt_upd) begin
							if (is_tx) begin
								tx_count_q <= cnt_d;
							end else begin
								rx_count_q <= cnt_d;
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (exec_go) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

`ifndef NO_ASSERTIONS
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_EXEC)
		else $error("accepted word did not enter execution");

	a_init_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INIT |-> req_stall)
		else $error("request taken during link initialization");

	a_write_owner: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_INIT || exec_go))
		else $error("link memory written outside init or execution");

	a_exec_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		exec_go |=> rsp_valid)
		else $error("completed word produced no response");

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_head_q <= NULL_LK)
		else $error("free list head beyond null");
`endif

endmodule
